[design/agc_pkg.sv]
// Shared constants, types and the log2 table of the AGC level to DAC code converter.
package agc_pkg;

	// DAC code resolution and log2 table size
	localparam int CODE_BITS      = 12;
	localparam int LOG_TABLE_BITS = 8;
	localparam int TABLE_SIZE     = 1 << LOG_TABLE_BITS;

	// Field widths
	localparam int MV_W       = 16;
	localparam int TGT_W      = 20;
	localparam int DAC_CODE_W = 12;
	localparam int CFG_INDEX_W = 8;
	localparam int CFG_DATA_W  = 20;
	localparam int CODE_EXT_W = (CODE_BITS > DAC_CODE_W) ? CODE_BITS : DAC_CODE_W;

	// Datapath widths of the log and polynomial stages
	localparam int LG_W  = 20;
	localparam int LN_W  = 20;
	localparam int SQ_W  = 24;
	localparam int BL_W  = 45;
	localparam int ASQ_W = 43;
	localparam int SUM_W = 47;

	// Code conversion: numerator mv*FULL + vref/2 always fits MV_W+CODE_BITS bits
	localparam int NUM_W = MV_W + CODE_BITS;
	localparam logic [CODE_BITS-1:0] FULL_CODE = {CODE_BITS{1'b1}};

	// Fixed-point constants: ln2 in Q16, coefficients in Q10.16
	localparam logic [15:0] LN2_Q16    = 16'd45426;
	localparam logic [18:0] COEF_A_Q16 = 19'd353595;
	localparam logic [24:0] COEF_B_Q16 = 25'd20127581;
	localparam logic [23:0] COEF_C_Q16 = 24'd11111607;

	// Configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] CFG_TARGET_MIN = 8'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_TARGET_MAX = 8'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_DAC_MAX    = 8'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_VREF       = 8'd3;

	// Configuration reset values
	localparam logic [TGT_W-1:0] TARGET_MIN_RST = 20'd16;
	localparam logic [TGT_W-1:0] TARGET_MAX_RST = 20'd1048575;
	localparam logic [MV_W-1:0]  DAC_MAX_RST    = 16'd3300;
	localparam logic [MV_W-1:0]  VREF_RST       = 16'd3300;

	// Request into the code divider
	typedef struct packed {
		logic [MV_W-1:0]  mv;
		logic [NUM_W-1:0] num;
	} div_req_t;

	// Result out of the code divider
	typedef struct packed {
		logic [MV_W-1:0]      mv;
		logic [CODE_BITS-1:0] code;
	} div_res_t;

	// log2(1 + i/TABLE_SIZE) in UQ0.16, truncated, by repeated squaring
	typedef logic [15:0] log2_tab_t [TABLE_SIZE];

	function automatic log2_tab_t build_log2_tab();
		log2_tab_t  tab;
		logic [63:0] m;
		logic [15:0] y;
		for (int i = 0; i < TABLE_SIZE; i++) begin
			m = (64'd1 << 30) + ((64'(i) << 30) >> LOG_TABLE_BITS);
			y = '0;
			for (int k = 1; k <= 16; k++) begin
				m = (m * m) >> 30;
				if (m >= (64'd2 << 30)) begin
					m = m >> 1;
					y = y | (16'd1 << (16 - k));
				end
			end
			tab[i] = y;
		end
		return tab;
	endfunction

	localparam log2_tab_t LOG2_TAB = build_log2_tab();

endpackage

[design/agc_div_pipe.sv]
// Pipelined restoring divider that turns a level numerator into a saturated DAC code.
module agc_div_pipe (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  agc_pkg::div_req_t        in_req,
	input  logic [agc_pkg::MV_W-1:0] vref,
	output logic                     out_valid,
	input  logic                     out_ready,
	output agc_pkg::div_res_t        out_res
);

	localparam int NSTG = agc_pkg::CODE_BITS;
	localparam int NW   = agc_pkg::NUM_W;

	// Stage registers, one quotient bit per stage, most significant first
	logic                          vld_s [NSTG];
	logic [NW-1:0]                 rem_s [NSTG];
	logic [agc_pkg::CODE_BITS-1:0] quo_s [NSTG];
	logic                          sat_s [NSTG];
	logic [agc_pkg::MV_W-1:0]      mv_s  [NSTG];

	logic                          en    [NSTG];
	logic                          vin   [NSTG];
	logic [NW-1:0]                 rin   [NSTG];
	logic [agc_pkg::CODE_BITS-1:0] qin   [NSTG];
	logic                          sin   [NSTG];
	logic [agc_pkg::MV_W-1:0]      min_v [NSTG];
	logic [NW-1:0]                 rnext [NSTG];
	logic [agc_pkg::CODE_BITS-1:0] qnext [NSTG];
	logic [NW-1:0]                 dsh   [NSTG];

	// Advance a stage when it is empty or the next one advances
	always_comb begin
		en[NSTG-1] = !vld_s[NSTG-1] || out_ready;
		for (int j = NSTG - 2; j >= 0; j--) begin
			en[j] = !vld_s[j] || en[j+1];
		end
	end

	assign in_ready = en[0];

	// Trial subtract of the shifted divisor at each stage
	always_comb begin
		for (int j = 0; j < NSTG; j++) begin
			if (j == 0) begin
				vin[j]   = in_valid;
				rin[j]   = in_req.num;
				qin[j]   = '0;
				sin[j]   = (in_req.num >= (NW'(vref) << NSTG));
				min_v[j] = in_req.mv;
			end else begin
				vin[j]   = vld_s[j-1];
				rin[j]   = rem_s[j-1];
				qin[j]   = quo_s[j-1];
				sin[j]   = sat_s[j-1];
				min_v[j] = mv_s[j-1];
			end
			dsh[j] = NW'(vref) << (NSTG - 1 - j);
			if (rin[j] >= dsh[j]) begin
				rnext[j] = rin[j] - dsh[j];
				qnext[j] = qin[j] | (agc_pkg::CODE_BITS'(1) << (NSTG - 1 - j));
			end else begin
				rnext[j] = rin[j];
				qnext[j] = qin[j];
			end
		end
	end

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < NSTG; j++) begin
				vld_s[j] <= 1'b0;
			end
		end else begin
			for (int j = 0; j < NSTG; j++) begin
				if (en[j]) begin
					vld_s[j] <= vin[j];
				end
			end
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		for (int j = 0; j < NSTG; j++) begin
			if (en[j]) begin
				rem_s[j] <= rnext[j];
				quo_s[j] <= qnext[j];
				sat_s[j] <= sin[j];
				mv_s[j]  <= min_v[j];
			end
		end
	end

	// Saturate the code when the quotient would pass full scale
	assign out_valid    = vld_s[NSTG-1];
	assign out_res.mv   = mv_s[NSTG-1];
	assign out_res.code = sat_s[NSTG-1] ? agc_pkg::FULL_CODE : quo_s[NSTG-1];

endmodule

[design/agc_level_to_dac_code.sv]
// Top level of the AGC level to DAC code converter: log, polynomial and code pipeline.
// Pipeline: 9 front stages (clamp, log2, ln, square, two products, sum, level, numerator)
// plus CODE_BITS divider stages, 21 register stages at CODE_BITS 12.
// Throughput: one request per cycle unless m_tready stalls the output; every stage is
// registered with its own valid bit.
// The code divider resolves one quotient bit per stage and sets the pipeline depth.
// Reset: arst_n clears all valid bits and loads the configuration defaults.
module agc_level_to_dac_code (
	input  logic        clk,
	input  logic        arst_n,
	// s_tdata: direct_mv [15:0], target_out_q4 [35:16], zero [39:36]
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,
	// s_tuser: req_type [0]
	input  logic [0:0]  s_tuser,
	// m_tdata: applied_mv [15:0], dac_code [27:16], zero [31:28]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [agc_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [agc_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int TW = agc_pkg::TGT_W;
	localparam int MW = agc_pkg::MV_W;

	// Configuration registers
	logic [TW-1:0] target_min_q;
	logic [TW-1:0] target_max_q;
	logic [MW-1:0] dac_max_q;
	logic [MW-1:0] vref_q;
	logic [MW-1:0] vref_eff;

	assign cfg_ready = 1'b1;
	assign vref_eff  = (vref_q == '0) ? MW'(1) : vref_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_min_q <= agc_pkg::TARGET_MIN_RST;
			target_max_q <= agc_pkg::TARGET_MAX_RST;
			dac_max_q    <= agc_pkg::DAC_MAX_RST;
			vref_q       <= agc_pkg::VREF_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				agc_pkg::CFG_TARGET_MIN: target_min_q <= cfg_data[TW-1:0];
				agc_pkg::CFG_TARGET_MAX: target_max_q <= cfg_data[TW-1:0];
				agc_pkg::CFG_DAC_MAX:    dac_max_q    <= cfg_data[MW-1:0];
				agc_pkg::CFG_VREF:       vref_q       <= cfg_data[MW-1:0];
				default: ;
			endcase
		end
	end

	// Pipeline registers
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9;
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6, en_s7, en_s8, en_s9;
	logic req_s1, req_s2, req_s3, req_s4, req_s5, req_s6, req_s7;
	logic [MW-1:0] dir_s1, dir_s2, dir_s3, dir_s4, dir_s5, dir_s6, dir_s7;
	logic [TW-1:0]                    tcl_s1;
	logic [agc_pkg::LG_W-1:0]         lg_s2;
	logic [agc_pkg::LN_W-1:0]         ln_s3, ln_s4;
	logic [agc_pkg::SQ_W-1:0]         sq_s4, sq_s5;
	logic [agc_pkg::BL_W-1:0]         bl_s5, bl_s6;
	logic [agc_pkg::ASQ_W-1:0]        asq_s6;
	logic [agc_pkg::SUM_W-1:0]        sum_s7;
	logic [MW-1:0]                    mv_s8;
	agc_pkg::div_req_t                dreq_s9;

	logic div_ready;

	// Advance a stage when it is empty or the next one advances
	assign en_s9 = !vld_s9 || div_ready;
	assign en_s8 = !vld_s8 || en_s9;
	assign en_s7 = !vld_s7 || en_s8;
	assign en_s6 = !vld_s6 || en_s7;
	assign en_s5 = !vld_s5 || en_s6;
	assign en_s4 = !vld_s4 || en_s5;
	assign en_s3 = !vld_s3 || en_s4;
	assign en_s2 = !vld_s2 || en_s3;
	assign en_s1 = !vld_s1 || en_s2;
	assign s_tready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
		end else begin
			if (en_s1) vld_s1 <= s_tvalid;
			if (en_s2) vld_s2 <= vld_s1;
			if (en_s3) vld_s3 <= vld_s2;
			if (en_s4) vld_s4 <= vld_s3;
			if (en_s5) vld_s5 <= vld_s4;
			if (en_s6) vld_s6 <= vld_s5;
			if (en_s7) vld_s7 <= vld_s6;
			if (en_s8) vld_s8 <= vld_s7;
			if (en_s9) vld_s9 <= vld_s8;
		end
	end

	// Stage 1: clamp the target, raising to the minimum first
	logic [TW-1:0] tgt_in;
	logic [TW-1:0] tcl_next;

	assign tgt_in = s_tdata[35:16];

	always_comb begin
		if (tgt_in < target_min_q) begin
			tcl_next = target_min_q;
		end else if (tgt_in > target_max_q) begin
			tcl_next = target_max_q;
		end else begin
			tcl_next = tgt_in;
		end
	end

	// Stage 2: log2 as leading-one position plus table fraction
	logic [4:0]                         msb_pos;
	logic [TW-1:0]                      norm;
	logic [agc_pkg::LOG_TABLE_BITS-1:0] tab_idx;
	logic [agc_pkg::LG_W-1:0]           lg_next;

	always_comb begin
		msb_pos = '0;
		for (int b = 0; b < TW; b++) begin
			if (tcl_s1[b]) begin
				msb_pos = 5'(b);
			end
		end
		norm    = tcl_s1 << (5'(TW - 1) - msb_pos);
		tab_idx = norm[TW-2 -: agc_pkg::LOG_TABLE_BITS];
		// Below one mV the log is held at zero
		if (tcl_s1 < TW'(16)) begin
			lg_next = '0;
		end else begin
			lg_next = {4'(msb_pos - 5'd4), agc_pkg::LOG2_TAB[tab_idx]};
		end
	end

	// Stage 3: ln = log2 * ln2, rounded half up
	logic [35:0] ln_sum;
	assign ln_sum = 36'(lg_s2) * 36'(agc_pkg::LN2_Q16) + 36'd32768;

	// Stage 4: square of ln, rounded half up to Q16
	logic [39:0] sq_sum;
	assign sq_sum = 40'(ln_s3) * 40'(ln_s3) + 40'd32768;

	// Stage 7: Q32 polynomial sum, signed
	logic [agc_pkg::SUM_W-1:0] sum_next;
	assign sum_next = agc_pkg::SUM_W'(bl_s6)
		+ (agc_pkg::SUM_W'(agc_pkg::COEF_C_Q16) << 16)
		- agc_pkg::SUM_W'(asq_s6);

	// Stage 8: round to mV, drop negative sums, choose path, clamp to DAC max
	logic [agc_pkg::SUM_W-1:0] sum_rnd;
	logic [MW-1:0]             poly_mv;
	logic [MW-1:0]             sel_mv;
	logic [MW-1:0]             mv_next;

	always_comb begin
		sum_rnd = sum_s7 + (agc_pkg::SUM_W'(1) << 31);
		// The sum stays below 2^45, so the rounded level fits without saturation
		if (sum_s7[agc_pkg::SUM_W-1] || (sum_s7 == '0)) begin
			poly_mv = '0;
		end else begin
			poly_mv = MW'(sum_rnd[agc_pkg::SUM_W-1:32]);
		end
		sel_mv  = req_s7 ? poly_mv : dir_s7;
		mv_next = (sel_mv > dac_max_q) ? dac_max_q : sel_mv;
	end

	// Stage 9: code numerator mv*FULL + vref/2
	agc_pkg::div_req_t dreq_next;
	assign dreq_next.mv  = mv_s8;
	assign dreq_next.num = agc_pkg::NUM_W'(mv_s8) * agc_pkg::NUM_W'(agc_pkg::FULL_CODE)
		+ agc_pkg::NUM_W'(vref_eff >> 1);

	// Payload of the front stages
	always_ff @(posedge clk) begin
		if (en_s1) begin
			req_s1 <= s_tuser[0];
			dir_s1 <= s_tdata[15:0];
			tcl_s1 <= tcl_next;
		end
		if (en_s2) begin
			req_s2 <= req_s1;
			dir_s2 <= dir_s1;
			lg_s2  <= lg_next;
		end
		if (en_s3) begin
			req_s3 <= req_s2;
			dir_s3 <= dir_s2;
			ln_s3  <= ln_sum[35:16];
		end
		if (en_s4) begin
			req_s4 <= req_s3;
			dir_s4 <= dir_s3;
			ln_s4  <= ln_s3;
			sq_s4  <= sq_sum[39:16];
		end
		if (en_s5) begin
			req_s5 <= req_s4;
			dir_s5 <= dir_s4;
			sq_s5  <= sq_s4;
			bl_s5  <= agc_pkg::BL_W'(ln_s4) * agc_pkg::BL_W'(agc_pkg::COEF_B_Q16);
		end
		if (en_s6) begin
			req_s6 <= req_s5;
			dir_s6 <= dir_s5;
			bl_s6  <= bl_s5;
			asq_s6 <= agc_pkg::ASQ_W'(sq_s5) * agc_pkg::ASQ_W'(agc_pkg::COEF_A_Q16);
		end
		if (en_s7) begin
			req_s7 <= req_s6;
			dir_s7 <= dir_s6;
			sum_s7 <= sum_next;
		end
		if (en_s8) begin
			mv_s8 <= mv_next;
		end
		if (en_s9) begin
			dreq_s9 <= dreq_next;
		end
	end

	// Code divider; its last stage is the output register and holds the last result
	agc_pkg::div_res_t dres;

	agc_div_pipe u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s9),
		.in_ready  (div_ready),
		.in_req    (dreq_s9),
		.vref      (vref_eff),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (dres)
	);

	// Mask the code to the 12-bit output field
	logic [agc_pkg::CODE_EXT_W-1:0] code_ext;
	logic [agc_pkg::CODE_EXT_W-1:0] full_ext;

	assign code_ext = agc_pkg::CODE_EXT_W'(dres.code);
	assign full_ext = agc_pkg::CODE_EXT_W'(agc_pkg::FULL_CODE);
	assign m_tdata  = {4'd0, code_ext[agc_pkg::DAC_CODE_W-1:0], dres.mv};

`ifndef ASSERT_OFF
	// Applied level never passes the DAC clamp
	a_mv_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[15:0] <= dac_max_q))
		else $error("applied level above DAC maximum");

	// Zero level gives code zero
	a_zero_code: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tdata[15:0] == '0)) |-> (m_tdata[27:16] == '0))
		else $error("zero level with nonzero code");

	// Level at or above vref gives full-scale code
	a_full_code: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tdata[15:0] >= vref_eff))
		|-> (m_tdata[27:16] == full_ext[agc_pkg::DAC_CODE_W-1:0]))
		else $error("level at vref without full-scale code");

	// An empty first stage always takes a request
	a_entry_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!vld_s1 |-> s_tready)
		else $error("empty pipeline refused a request");
`endif

endmodule
